// ===== hdl/owbg_pkg.sv =====
// ---------------------------------------------------------------------------
// owbg_pkg : shared types, constants and divider steps
// Widths, status codes and one restoring-division step for each divider
// phase of the white-balance gain pipeline.
// ---------------------------------------------------------------------------
package owbg_pkg;

    localparam int RatioW = 10;          // ratio width
    localparam int GainW  = 16;          // output gain width
    localparam int Q1W    = 20;          // raw gain quotient width
    localparam int D2W    = 11;          // base divisor width (up to 0x400)
    localparam int Q2W    = 30;          // final gain quotient width
    localparam int S1W    = Q1W + RatioW;
    localparam int S2W    = Q2W + D2W;

    localparam logic [Q1W-1:0]   UnityQ1  = Q1W'(16'h0400);
    localparam logic [Q2W-1:0]   UnityQ2  = Q2W'(16'h0400);
    localparam logic [D2W-1:0]   UnityD2  = D2W'(16'h0400);
    localparam logic [GainW-1:0] UnityG   = 16'h0400;
    localparam logic [GainW-1:0] GainMax  = 16'hffff;

    typedef logic [1:0] status_t;
    localparam status_t StatusOk      = 2'd0;
    localparam status_t StatusNoData  = 2'd1;
    localparam status_t StatusZeroDiv = 2'd2;
    localparam status_t StatusSat     = 2'd3;

    localparam logic CfgTypRg = 1'b0;
    localparam logic CfgTypBg = 1'b1;

    // one quotient bit of the raw-gain divider; state is {rem, dividend/quotient}
    function automatic logic [S1W-1:0] div1_step(input logic [S1W-1:0] s,
                                                 input logic [RatioW-1:0] d);
        logic [RatioW:0]   t;
        logic              ge;
        logic [RatioW:0]   r;
        begin
            t  = {s[S1W-1:Q1W], s[Q1W-1]};
            ge = (t >= {1'b0, d});
            r  = ge ? (t - {1'b0, d}) : t;
            div1_step = {r[RatioW-1:0], s[Q1W-2:0], ge};
        end
    endfunction

    // one quotient bit of the normalising divider
    function automatic logic [S2W-1:0] div2_step(input logic [S2W-1:0] s,
                                                 input logic [D2W-1:0] d);
        logic [D2W:0] t;
        logic         ge;
        logic [D2W:0] r;
        begin
            t  = {s[S2W-1:Q2W], s[Q2W-1]};
            ge = (t >= {1'b0, d});
            r  = ge ? (t - {1'b0, d}) : t;
            div2_step = {r[D2W-1:0], s[Q2W-2:0], ge};
        end
    endfunction

endpackage

// ===== hdl/otp_white_balance_gain.sv =====
// ---------------------------------------------------------------------------
// otp_white_balance_gain : white-balance gains from calibration ratios
// Two pipelined restoring dividers give raw gains, a base stage picks the
// normaliser, and three more pipelined dividers give the final gains.
// ---------------------------------------------------------------------------
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+-------------
//  input    | wb_valid, measured_rg, measured_bg        | in_valid/in_ready
//  result   | *_gain, *_write, status                   | out_valid/out_ready
//  config   | cfg_index, cfg_data                       | cfg_we, no wait
//
//  One request accepted per cycle while the output is not stalled; the pipe
//  has 1 capture, 20 raw divider stages, 1 base stage, 30 normalising stages
//  and 1 output register. The divider chains take one quotient bit per stage.
//  Reset clears all stage valid bits and loads both typical ratios with 256.
//  A stalled output freezes the whole pipe; in_ready follows it.
// ---------------------------------------------------------------------------
module otp_white_balance_gain
    import owbg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [RatioW-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              wb_valid,
    input  logic [RatioW-1:0] measured_rg,
    input  logic [RatioW-1:0] measured_bg,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [GainW-1:0]  red_gain,
    output logic [GainW-1:0]  green_gain,
    output logic [GainW-1:0]  blue_gain,
    output logic              red_write,
    output logic              green_write,
    output logic              blue_write,
    output logic [1:0]        status
);

    localparam int NA = Q1W;   // raw divider steps
    localparam int NB = Q2W;   // normalising divider steps

    logic [RatioW-1:0] typ_rg_reg, typ_bg_reg;

    // raw gain pipe
    logic              a_v_reg  [0:NA];
    status_t           a_st_reg [0:NA];
    logic [S1W-1:0]    a_r_reg  [0:NA];
    logic [S1W-1:0]    a_b_reg  [0:NA];
    logic [RatioW-1:0] a_dr_reg [0:NA];
    logic [RatioW-1:0] a_db_reg [0:NA];

    // normalising pipe
    logic              b_v_reg  [0:NB];
    status_t           b_st_reg [0:NB];
    logic [S2W-1:0]    b_r_reg  [0:NB];
    logic [S2W-1:0]    b_g_reg  [0:NB];
    logic [S2W-1:0]    b_b_reg  [0:NB];
    logic [D2W-1:0]    b_d_reg  [0:NB];

    // output register
    logic              o_v_reg;
    logic [GainW-1:0]  o_r_reg, o_g_reg, o_b_reg;
    logic              o_wr_reg, o_wg_reg, o_wb_reg;
    status_t           o_st_reg;

    logic adv;
    assign adv      = !o_v_reg || out_ready;
    assign in_ready = adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            typ_rg_reg <= RatioW'(256);
            typ_bg_reg <= RatioW'(256);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CfgTypRg)
                typ_rg_reg <= cfg_data;
            else
                typ_bg_reg <= cfg_data;
        end
    end

    // base selection, combinational ahead of the normalising pipe
    logic [Q1W-1:0] raw_r, raw_b, min_rb;
    logic [D2W-1:0] base_next;
    status_t        bst_next;
    assign raw_r  = a_r_reg[NA][Q1W-1:0];
    assign raw_b  = a_b_reg[NA][Q1W-1:0];
    assign min_rb = (raw_r < raw_b) ? raw_r : raw_b;

    always_comb
    begin
        if (raw_r < UnityQ1 || raw_b < UnityQ1)
            base_next = D2W'(min_rb[RatioW-1:0]);
        else
            base_next = UnityD2;
        if (a_st_reg[NA] == StatusOk && base_next == '0)
            bst_next = StatusZeroDiv;
        else
            bst_next = a_st_reg[NA];
    end

    // output clamp and flags
    logic [Q2W-1:0] qr, qg, qb;
    logic           sat_next;
    status_t        ost_next;
    assign qr = b_r_reg[NB][Q2W-1:0];
    assign qg = b_g_reg[NB][Q2W-1:0];
    assign qb = b_b_reg[NB][Q2W-1:0];
    assign sat_next = (qr > Q2W'(GainMax)) || (qg > Q2W'(GainMax)) || (qb > Q2W'(GainMax));

    always_comb
    begin
        if (b_st_reg[NB] != StatusOk)
            ost_next = b_st_reg[NB];
        else if (sat_next)
            ost_next = StatusSat;
        else
            ost_next = StatusOk;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NA; i++)
                a_v_reg[i] <= 1'b0;
            for (int i = 0; i <= NB; i++)
                b_v_reg[i] <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg[0] <= in_valid;
            for (int i = 1; i <= NA; i++)
                a_v_reg[i] <= a_v_reg[i-1];
            b_v_reg[0] <= a_v_reg[NA];
            for (int i = 1; i <= NB; i++)
                b_v_reg[i] <= b_v_reg[i-1];
            o_v_reg <= b_v_reg[NB];
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // capture
            if (!wb_valid)
                a_st_reg[0] <= StatusNoData;
            else if (measured_rg == '0 || measured_bg == '0)
                a_st_reg[0] <= StatusZeroDiv;
            else
                a_st_reg[0] <= StatusOk;
            a_r_reg[0]  <= {RatioW'(0), typ_rg_reg, RatioW'(0)};
            a_b_reg[0]  <= {RatioW'(0), typ_bg_reg, RatioW'(0)};
            a_dr_reg[0] <= measured_rg;
            a_db_reg[0] <= measured_bg;
            // raw gain division
            for (int i = 1; i <= NA; i++)
            begin
                a_st_reg[i] <= a_st_reg[i-1];
                a_r_reg[i]  <= div1_step(a_r_reg[i-1], a_dr_reg[i-1]);
                a_b_reg[i]  <= div1_step(a_b_reg[i-1], a_db_reg[i-1]);
                a_dr_reg[i] <= a_dr_reg[i-1];
                a_db_reg[i] <= a_db_reg[i-1];
            end
            // base stage
            b_st_reg[0] <= bst_next;
            b_d_reg[0]  <= base_next;
            b_r_reg[0]  <= {D2W'(0), raw_r, RatioW'(0)};
            b_g_reg[0]  <= {D2W'(0), UnityQ1, RatioW'(0)};
            b_b_reg[0]  <= {D2W'(0), raw_b, RatioW'(0)};
            // normalising division
            for (int i = 1; i <= NB; i++)
            begin
                b_st_reg[i] <= b_st_reg[i-1];
                b_d_reg[i]  <= b_d_reg[i-1];
                b_r_reg[i]  <= div2_step(b_r_reg[i-1], b_d_reg[i-1]);
                b_g_reg[i]  <= div2_step(b_g_reg[i-1], b_d_reg[i-1]);
                b_b_reg[i]  <= div2_step(b_b_reg[i-1], b_d_reg[i-1]);
            end
            // output
            o_st_reg <= ost_next;
            if (b_st_reg[NB] != StatusOk)
            begin
                o_r_reg  <= UnityG;
                o_g_reg  <= UnityG;
                o_b_reg  <= UnityG;
                o_wr_reg <= 1'b0;
                o_wg_reg <= 1'b0;
                o_wb_reg <= 1'b0;
            end
            else
            begin
                o_r_reg  <= (qr > Q2W'(GainMax)) ? GainMax : qr[GainW-1:0];
                o_g_reg  <= (qg > Q2W'(GainMax)) ? GainMax : qg[GainW-1:0];
                o_b_reg  <= (qb > Q2W'(GainMax)) ? GainMax : qb[GainW-1:0];
                o_wr_reg <= (qr > UnityQ2);
                o_wg_reg <= (qg > UnityQ2);
                o_wb_reg <= (qb > UnityQ2);
            end
        end
    end

    assign out_valid   = o_v_reg;
    assign red_gain    = o_r_reg;
    assign green_gain  = o_g_reg;
    assign blue_gain   = o_b_reg;
    assign red_write   = o_wr_reg;
    assign green_write = o_wg_reg;
    assign blue_write  = o_wb_reg;
    assign status      = o_st_reg;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb : white-balance gain testbench
// Drives calibration ratio requests with random idling on both channels,
// predicts the gains and status of each request and checks every result in
// order. The typical ratios are changed between phases while the pipe is idle.
// ---------------------------------------------------------------------------

// gain set predicted for one request
typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        red_wr;
    logic        green_wr;
    logic        blue_wr;
    logic [1:0]  st;
} gain_set_t;

class gain_board;
    logic [9:0]  typ_rg;
    logic [9:0]  typ_bg;
    gain_set_t   pending[$];
    int          mismatches;
    int          checked;

    function new();
        typ_rg     = 10'd256;
        typ_bg     = 10'd256;
        mismatches = 0;
        checked    = 0;
    endfunction

    // work out the gains for an accepted request
    function void note_request(logic ok, logic [9:0] mrg, logic [9:0] mbg);
        gain_set_t   e;
        logic [63:0] r;
        logic [63:0] g;
        logic [63:0] b;
        logic [63:0] base;
        e = '0;
        e.red   = 16'h0400;
        e.green = 16'h0400;
        e.blue  = 16'h0400;
        if (!ok)
        begin
            e.st = owbg_pkg::StatusNoData;
        end
        else if (mrg == 0 || mbg == 0)
        begin
            e.st = owbg_pkg::StatusZeroDiv;
        end
        else
        begin
            r = (64'h400 * typ_rg) / mrg;
            b = (64'h400 * typ_bg) / mbg;
            g = 64'h400;
            base = (r < 64'h400 || b < 64'h400) ? ((r < b) ? r : b) : g;
            if (base == 0)
            begin
                e.st = owbg_pkg::StatusZeroDiv;
            end
            else
            begin
                r = (64'h400 * r) / base;
                g = (64'h400 * g) / base;
                b = (64'h400 * b) / base;
                e.red_wr   = r > 64'h400;
                e.green_wr = g > 64'h400;
                e.blue_wr  = b > 64'h400;
                e.st = (r > 64'hffff || g > 64'hffff || b > 64'hffff)
                       ? owbg_pkg::StatusSat : owbg_pkg::StatusOk;
                e.red   = (r > 64'hffff) ? 16'hffff : r[15:0];
                e.green = (g > 64'hffff) ? 16'hffff : g[15:0];
                e.blue  = (b > 64'hffff) ? 16'hffff : b[15:0];
            end
        end
        pending.push_back(e);
    endfunction

    // compare one result with the oldest prediction
    function void check_result(gain_set_t got);
        gain_set_t e;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h", got);
            return;
        end
        e = pending.pop_front();
        checked++;
        if (got !== e)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp r%h g%h b%h w%b%b%b s%0d got r%h g%h b%h w%b%b%b s%0d",
                         e.red, e.green, e.blue, e.red_wr, e.green_wr, e.blue_wr, e.st,
                         got.red, got.green, got.blue, got.red_wr, got.green_wr,
                         got.blue_wr, got.st);
        end
    endfunction
endclass

module tb;
    import owbg_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [9:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        wb_valid;
    logic [9:0]  measured_rg;
    logic [9:0]  measured_bg;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] red_gain;
    logic [15:0] green_gain;
    logic [15:0] blue_gain;
    logic        red_write;
    logic        green_write;
    logic        blue_write;
    logic [1:0]  status;

    gain_board board;
    bit        calm;
    int        sent;

    otp_white_balance_gain dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // sample both channels at the edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_request(wb_valid, measured_rg, measured_bg);
        if (rst_n && out_valid && out_ready)
            board.check_result({red_gain, green_gain, blue_gain,
                                red_write, green_write, blue_write, status});
    end

    // result side stalls
    always @(posedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);

    // one register write, then the write port is left quiet
    task automatic write_reg(logic idx, logic [9:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.typ_rg = (idx == CfgTypRg) ? val : board.typ_rg;
        board.typ_bg = (idx == CfgTypBg) ? val : board.typ_bg;
        @(posedge clk);
    endtask

    task automatic send(logic ok, logic [9:0] mrg, logic [9:0] mbg);
        while (!calm && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        wb_valid    <= ok;
        measured_rg <= mrg;
        measured_bg <= mbg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic random_burst(int n);
        logic [9:0] a;
        logic [9:0] b;
        for (int i = 0; i < n; i++)
        begin
            a = 10'($urandom_range(1023));
            b = 10'($urandom_range(1023));
            if ($urandom_range(9) == 0) a = 10'($urandom_range(3));
            if ($urandom_range(9) == 0) b = 10'($urandom_range(3));
            send($urandom_range(15) != 0, a, b);
        end
    endtask

    initial
    begin
        board       = new();
        calm        = 1'b0;
        sent        = 0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CfgTypRg;
        cfg_data    = '0;
        in_valid    = 1'b0;
        wb_valid    = 1'b0;
        measured_rg = '0;
        measured_bg = '0;
        out_ready   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset ratios, extremes, no data, zero divisor, saturation
        send(1'b0, 10'd300, 10'd300);
        send(1'b1, 10'd256, 10'd256);
        send(1'b1, 10'd0, 10'd100);
        send(1'b1, 10'd100, 10'd0);
        send(1'b1, 10'd1, 10'd1);
        send(1'b1, 10'd1, 10'd1023);
        send(1'b1, 10'd1023, 10'd1);
        send(1'b1, 10'd1023, 10'd1023);
        send(1'b1, 10'd128, 10'd512);
        send(1'b1, 10'd2, 10'd300);
        drain();
        write_reg(CfgTypRg, 10'd0);
        write_reg(CfgTypBg, 10'd1023);
        send(1'b1, 10'd500, 10'd500);
        send(1'b1, 10'd1023, 10'd1);
        send(1'b1, 10'd1, 10'd1023);
        drain();
        write_reg(CfgTypRg, 10'd1023);
        write_reg(CfgTypBg, 10'd1);
        send(1'b1, 10'd1, 10'd1023);
        send(1'b1, 10'd1023, 10'd1023);
        send(1'b1, 10'd1, 10'd1);
        drain();

        // random phases over several register settings
        for (int p = 0; p < 6; p++)
        begin
            write_reg(CfgTypRg, (p == 0) ? 10'd256 : 10'($urandom_range(1023)));
            write_reg(CfgTypBg, (p == 0) ? 10'd256 : 10'($urandom_range(1023)));
            calm = (p == 3);
            random_burst(90);
            drain();
        end
        calm = 1'b0;

        $display("tb: %0d requests sent, %0d results checked over 9 register settings",
                 sent, board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end
endmodule
